// ===== design/clj_pkg.sv =====
package clj_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam int CFG_INDEX_W = 8;

  localparam logic [15:0] PC_RESET = 16'hFFFC;

  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_X = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_Y = 8'd1;

  localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
  localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
  localparam logic [7:0] OP_LDA_INDX = 8'hA1;
  localparam logic [7:0] OP_LDA_INDY = 8'hB1;
  localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
  localparam logic [7:0] OP_JMP_IND  = 8'h6C;

  localparam logic [7:0] SIGN_MASK = 8'b1000_0000;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_STEP  = 1'b1
  } kind_code_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  acc;
    logic        zero_flag;
    logic        negative_flag;
    logic [7:0]  opcode;
    logic        unhandled;
  } result_t;

  // memory address source
  typedef enum logic [3:0] {
    ASEL_PC,
    ASEL_WR,
    ASEL_ZP,
    ASEL_ZPX,
    ASEL_WORD,
    ASEL_WORD_X,
    ASEL_WORD_Y,
    ASEL_PTR_INC,
    ASEL_ZPTR_INC
  } asel_t;

  typedef struct packed {
    asel_t asel;
    logic  mem_we;
    logic  step_begin;
    logic  pc_inc;
    logic  pc_load_word;
    logic  lo_load;
    logic  ptr_load;
    logic  acc_load;
    logic  op_load;
    logic  bad_set;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] op;
  } dp_status_t;

endpackage

// ===== design/clj_ram.sv =====
module clj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/clj_dp.sv =====
module clj_dp
  import clj_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  item_t                  item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output result_t                result
);

  logic [ADDR_BITS-1:0] pc;
  logic [7:0]           acc;
  logic                 zf;
  logic                 nf;
  logic [7:0]           op;
  logic                 bad;
  logic [7:0]           lo;
  logic [ADDR_BITS-1:0] ptr;
  logic [7:0]           index_x;
  logic [7:0]           index_y;

  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           rdata;
  logic [15:0]          word16;
  logic [ADDR_BITS-1:0] word;
  logic [15:0]          pc_ext;

  function automatic logic [ADDR_BITS-1:0] zext8(input logic [7:0] v);
    logic [ADDR_BITS-1:0] r;
    r = '0;
    r[7:0] = v;
    return r;
  endfunction

  assign word16 = {rdata, lo};
  assign word   = word16[ADDR_BITS-1:0];

  always_comb begin
    case (cmd.asel)
      ASEL_PC:       mem_addr = pc;
      ASEL_WR:       mem_addr = item.address[ADDR_BITS-1:0];
      ASEL_ZP:       mem_addr = zext8(rdata);
      ASEL_ZPX:      mem_addr = zext8(rdata + index_x);
      ASEL_WORD:     mem_addr = word;
      ASEL_WORD_X:   mem_addr = word + zext8(index_x);
      ASEL_WORD_Y:   mem_addr = word + zext8(index_y);
      ASEL_PTR_INC:  mem_addr = ptr + zext8(8'd1);
      ASEL_ZPTR_INC: mem_addr = zext8(ptr[7:0] + 8'd1);
      default:       mem_addr = pc;
    endcase
  end

  clj_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.mem_we),
    .addr (mem_addr),
    .wdata(item.data),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= PC_RESET[ADDR_BITS-1:0];
      acc     <= '0;
      zf      <= 1'b0;
      nf      <= 1'b0;
      op      <= '0;
      bad     <= 1'b0;
      index_x <= '0;
      index_y <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_INDEX_X) begin
        index_x <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_INDEX_Y) begin
        index_y <= cfg_data;
      end
      if (cmd.mem_we) begin
        op  <= '0;
        bad <= 1'b0;
      end
      if (cmd.step_begin) begin
        bad <= 1'b0;
      end
      if (cmd.op_load) begin
        op <= rdata;
      end
      if (cmd.bad_set) begin
        bad <= 1'b1;
      end
      if (cmd.pc_load_word) begin
        pc <= word;
      end else if (cmd.pc_inc) begin
        pc <= pc + zext8(8'd1);
      end
      if (cmd.acc_load) begin
        acc <= rdata;
        zf  <= (rdata == 8'd0);
        nf  <= ((rdata & SIGN_MASK) != 8'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lo_load) begin
      lo <= rdata;
    end
    if (cmd.ptr_load) begin
      ptr <= mem_addr;
    end
  end

  always_comb begin
    pc_ext = '0;
    pc_ext[ADDR_BITS-1:0] = pc;
  end

  assign status.rdata = rdata;
  assign status.op    = op;

  assign result.pc            = pc_ext;
  assign result.acc           = acc;
  assign result.zero_flag     = zf;
  assign result.negative_flag = nf;
  assign result.opcode        = op;
  assign result.unhandled     = bad;

endmodule

// ===== design/clj_ctrl.sv =====
module clj_ctrl
  import clj_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       kind,
  output logic       busy,
  output logic       done,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP,
    S_IMM,
    S_ZP,
    S_ZPX,
    S_ABS_LO,
    S_ABS_HI,
    S_IND_LO,
    S_JMP_HI,
    S_PTR,
    S_PTR_LO,
    S_PTR_HI,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.asel   = ASEL_PC;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_WRITE) begin
            cmd.asel   = ASEL_WR;
            cmd.mem_we = 1'b1;
            done_next  = 1'b1;
          end else begin
            cmd.step_begin = 1'b1;
            cmd.pc_inc     = 1'b1;
            state_next     = S_OP;
          end
        end
      end
      S_OP: begin
        cmd.op_load = 1'b1;
        cmd.pc_inc  = 1'b1;
        case (status.rdata)
          OP_LDA_IMM:  state_next = S_IMM;
          OP_LDA_ZP:   state_next = S_ZP;
          OP_LDA_ZPX:  state_next = S_ZPX;
          OP_LDA_ABS, OP_LDA_ABSX, OP_LDA_ABSY, OP_JMP_ABS, OP_JMP_IND:
            state_next = S_ABS_LO;
          OP_LDA_INDX, OP_LDA_INDY:
            state_next = S_PTR;
          default: begin
            cmd.pc_inc  = 1'b0;
            cmd.bad_set = 1'b1;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        endcase
      end
      S_IMM: begin
        cmd.acc_load = 1'b1;
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      S_ZP: begin
        cmd.asel   = ASEL_ZP;
        state_next = S_LOAD;
      end
      S_ZPX: begin
        cmd.asel   = ASEL_ZPX;
        state_next = S_LOAD;
      end
      S_ABS_LO: begin
        cmd.lo_load = 1'b1;
        cmd.pc_inc  = 1'b1;
        state_next  = S_ABS_HI;
      end
      S_ABS_HI: begin
        case (status.op)
          OP_LDA_ABSX: begin
            cmd.asel   = ASEL_WORD_X;
            state_next = S_LOAD;
          end
          OP_LDA_ABSY: begin
            cmd.asel   = ASEL_WORD_Y;
            state_next = S_LOAD;
          end
          OP_JMP_ABS: begin
            cmd.pc_load_word = 1'b1;
            done_next        = 1'b1;
            state_next       = S_IDLE;
          end
          OP_JMP_IND: begin
            cmd.asel     = ASEL_WORD;
            cmd.ptr_load = 1'b1;
            state_next   = S_IND_LO;
          end
          default: begin
            cmd.asel   = ASEL_WORD;
            state_next = S_LOAD;
          end
        endcase
      end
      S_IND_LO: begin
        cmd.lo_load = 1'b1;
        cmd.asel    = ASEL_PTR_INC;
        state_next  = S_JMP_HI;
      end
      S_JMP_HI: begin
        cmd.pc_load_word = 1'b1;
        done_next        = 1'b1;
        state_next       = S_IDLE;
      end
      S_PTR: begin
        // operand byte (plus X for LDA (zp,X)) is the zero-page pointer address
        cmd.asel     = (status.op == OP_LDA_INDX) ? ASEL_ZPX : ASEL_ZP;
        cmd.ptr_load = 1'b1;
        state_next   = S_PTR_LO;
      end
      S_PTR_LO: begin
        cmd.lo_load = 1'b1;
        cmd.asel    = ASEL_ZPTR_INC;
        state_next  = S_PTR_HI;
      end
      S_PTR_HI: begin
        cmd.asel   = (status.op == OP_LDA_INDY) ? ASEL_WORD_Y : ASEL_WORD;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.acc_load = 1'b1;
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

// ===== design/cpu_load_jump_subset.sv =====
// 8-bit core subset: LDA in eight addressing modes plus JMP absolute/indirect,
// running out of a single-port byte RAM.
//
// Item channel: an item is taken on a clock edge with start high and busy low.
// A write item (kind 0) stores data at address; a step item (kind 1) fetches
// and executes one instruction at PC.
// Result channel: done pulses for one cycle with result holding PC, A, the
// Z/N flags, the fetched opcode and the unhandled flag. The receiver cannot
// stall; each result is valid only during its done cycle.
// Config channel: cfg_valid/cfg_ready (ready is always high), cfg_index 0
// writes X, 1 writes Y, other indexes are dropped. Write only while idle.
// Completion: done is registered from the controller state; a step item walks
// its states one RAM read at a time (opcode, operands, pointer, data) since
// the RAM has one port with a registered read. busy stays low for a write item
// and drops with done after a step item, so the next item may start in the done cycle.
// Reset: PC = 0xFFFC, A, flags, X and Y cleared; RAM contents are undefined
// until written.
module cpu_load_jump_subset
  import clj_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  clj_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .status(status)
  );

  clj_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !busy && !done)
    else $error("busy or done right after reset");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("done without an item in flight");

  a_unhandled_op: assert property (@(posedge clk) disable iff (rst)
    done && result.unhandled |->
      result.opcode != OP_LDA_IMM && result.opcode != OP_LDA_ZP &&
      result.opcode != OP_JMP_ABS && result.opcode != OP_JMP_IND)
    else $error("supported opcode flagged as unhandled");
`endif

endmodule

// ===== tb/sv/cpu_load_jump_subset_tb.sv =====
`timescale 1ns / 100ps

module cpu_load_jump_subset_tb;
  import clj_pkg::*;

  typedef bit [ADDR_BITS-1:0] addr_t;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_ITEMS = 190;

  // Shadow copy of the core: memory image, registers, and the results still owed.
  class cpu_mirror;
    bit [7:0] mem [MEM_DEPTH];
    bit       mem_set [MEM_DEPTH];
    addr_t    pc = addr_t'(PC_RESET);
    bit [7:0] acc;
    bit [7:0] reg_x;
    bit [7:0] reg_y;
    bit       zf;
    bit       nf;
    bit       hole_found;
    addr_t    hole_addr;
    result_t  results_due[$];
    int       mismatches;

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
      if (idx == CFG_INDEX_X) reg_x = val;
      else if (idx == CFG_INDEX_Y) reg_y = val;
    endfunction

    // remembers the first byte read that was never written
    function bit [7:0] rd(addr_t a);
      if (!mem_set[a] && !hole_found) begin
        hole_found = 1'b1;
        hole_addr = a;
      end
      return mem[a];
    endfunction

    function bit [7:0] fetch(inout addr_t p);
      fetch = rd(p);
      p = p + 1'b1;
    endfunction

    function addr_t fetch_word(inout addr_t p);
      bit [7:0] lo;
      bit [7:0] hi;
      lo = fetch(p);
      hi = fetch(p);
      return addr_t'({hi, lo});
    endfunction

    // pointer bytes live in zero page; pointer+1 wraps at 8 bits
    function bit [15:0] zp_pointer(bit [7:0] zp);
      bit [7:0] lo;
      bit [7:0] zp_next;
      zp_next = zp + 8'd1;
      lo = rd(addr_t'(zp));
      return {rd(addr_t'(zp_next)), lo};
    endfunction

    // commit = 0 only probes which bytes the next step would read
    function result_t run_step(bit commit);
      addr_t    p;
      addr_t    ea;
      bit [7:0] op;
      bit [7:0] b;
      bit [7:0] v;
      bit [7:0] lo;
      bit [7:0] hi;
      bit [7:0] a;
      bit       z;
      bit       n;
      bit       ld;
      bit       bad;
      result_t  r;
      p = pc;
      a = acc;
      z = zf;
      n = nf;
      v = 8'd0;
      ld = 1'b0;
      bad = 1'b0;
      hole_found = 1'b0;
      op = fetch(p);
      case (op)
        OP_LDA_IMM: begin
          v = fetch(p);
          ld = 1'b1;
        end
        OP_LDA_ZP: begin
          b = fetch(p);
          v = rd(addr_t'(b));
          ld = 1'b1;
        end
        OP_LDA_ZPX: begin
          b = fetch(p);
          b = b + reg_x;
          v = rd(addr_t'(b));
          ld = 1'b1;
        end
        OP_LDA_ABS: begin
          v = rd(fetch_word(p));
          ld = 1'b1;
        end
        OP_LDA_ABSX: begin
          ea = fetch_word(p) + reg_x;
          v = rd(ea);
          ld = 1'b1;
        end
        OP_LDA_ABSY: begin
          ea = fetch_word(p) + reg_y;
          v = rd(ea);
          ld = 1'b1;
        end
        OP_LDA_INDX: begin
          b = fetch(p);
          b = b + reg_x;
          ea = addr_t'(zp_pointer(b));
          v = rd(ea);
          ld = 1'b1;
        end
        OP_LDA_INDY: begin
          b = fetch(p);
          ea = addr_t'(zp_pointer(b) + reg_y);
          v = rd(ea);
          ld = 1'b1;
        end
        OP_JMP_ABS: begin
          ea = fetch_word(p);
          p = ea;
        end
        OP_JMP_IND: begin
          ea = fetch_word(p);
          lo = rd(ea);
          ea = ea + 1'b1;
          hi = rd(ea);
          p = addr_t'({hi, lo});
        end
        default: bad = 1'b1;
      endcase
      if (ld) begin
        a = v;
        z = (v == 8'd0);
        n = ((v & SIGN_MASK) != 8'd0);
      end
      r.pc = 16'(p);
      r.acc = a;
      r.zero_flag = z;
      r.negative_flag = n;
      r.opcode = op;
      r.unhandled = bad;
      if (commit) begin
        pc = p;
        acc = a;
        zf = z;
        nf = n;
      end
      return r;
    endfunction

    function void take_item(item_t it);
      result_t r;
      if (it.kind == 1'(KIND_STEP)) begin
        r = run_step(1'b1);
      end else begin
        mem[addr_t'(it.address)] = it.data;
        mem_set[addr_t'(it.address)] = 1'b1;
        r.pc = 16'(pc);
        r.acc = acc;
        r.zero_flag = zf;
        r.negative_flag = nf;
        r.opcode = 8'd0;
        r.unhandled = 1'b0;
      end
      results_due.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pc=%h acc=%h z=%b n=%b op=%h unh=%b",
                   got.pc, got.acc, got.zero_flag, got.negative_flag, got.opcode,
                   got.unhandled);
        return;
      end
      want = results_due.pop_front();
      if (got.pc !== want.pc || got.acc !== want.acc || got.zero_flag !== want.zero_flag ||
          got.negative_flag !== want.negative_flag || got.opcode !== want.opcode ||
          got.unhandled !== want.unhandled) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected pc=%h acc=%h z=%b n=%b op=%h unh=%b, got pc=%h acc=%h z=%b n=%b op=%h unh=%b",
                   want.pc, want.acc, want.zero_flag, want.negative_flag, want.opcode,
                   want.unhandled, got.pc, got.acc, got.zero_flag, got.negative_flag,
                   got.opcode, got.unhandled);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  item_t                  item = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  cpu_mirror mirror = new();
  int        cycles = 0;
  int        sent = 0;
  int        calm_left = 0;

  cpu_load_jump_subset u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) mirror.check_result(result);
  end

  // start stays high across back-to-back items; it only drops for a gap
  task automatic send_item(input item_t it);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 6);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    mirror.take_item(it);
    sent++;
  endtask

  task automatic poke(input addr_t a, input logic [7:0] d);
    item_t it;
    it.kind = 1'(KIND_WRITE);
    it.address = 16'(a);
    it.data = d;
    send_item(it);
  endtask

  // write random bytes wherever the next instruction would read unwritten memory
  task automatic fill_and_step();
    item_t it;
    void'(mirror.run_step(1'b0));
    while (mirror.hole_found) begin
      poke(mirror.hole_addr, 8'($urandom));
      void'(mirror.run_step(1'b0));
    end
    it.kind = 1'(KIND_STEP);
    it.address = 16'($urandom);
    it.data = 8'($urandom);
    send_item(it);
  endtask

  task automatic put_instr(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
    addr_t at;
    at = mirror.pc;
    poke(at, op);
    case (op)
      OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ZPX, OP_LDA_INDX, OP_LDA_INDY: begin
        poke(at + 1'b1, lo);
      end
      OP_LDA_ABS, OP_LDA_ABSX, OP_LDA_ABSY, OP_JMP_ABS, OP_JMP_IND: begin
        poke(at + 1'b1, lo);
        poke(at + 2'd2, hi);
      end
      default: ;
    endcase
    fill_and_step();
  endtask

  task automatic rand_instr();
    logic [7:0] op;
    logic [7:0] hi;
    // often re-run code that is already in memory
    if (!mirror.mem_set[mirror.pc] || $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 11))
        0: op = OP_LDA_IMM;
        1: op = OP_LDA_ZP;
        2: op = OP_LDA_ZPX;
        3: op = OP_LDA_ABS;
        4: op = OP_LDA_ABSX;
        5: op = OP_LDA_ABSY;
        6: op = OP_LDA_INDX;
        7: op = OP_LDA_INDY;
        8: op = OP_JMP_ABS;
        9: op = OP_JMP_IND;
        default: op = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: hi = 8'h00;
        1: hi = 8'hFF;
        default: hi = 8'($urandom);
      endcase
      put_instr(op, 8'($urandom), hi);
    end else begin
      fill_and_step();
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    mirror.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (mirror.results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // X = Y = 0 from reset; code starts at the reset vector and wraps past 0xFFFF
    put_instr(OP_LDA_IMM, 8'h00, 8'h00);
    put_instr(OP_LDA_IMM, 8'h80, 8'h00);
    put_instr(8'hFF, 8'h00, 8'h00);
    poke(addr_t'(16'h00FF), 8'h7F);
    put_instr(OP_LDA_ZP, 8'hFF, 8'h00);
    put_instr(OP_LDA_ABS, 8'hFF, 8'hFF);
    // pointer at 0xFFFF: high byte comes from 0x0000
    put_instr(OP_JMP_IND, 8'hFF, 8'hFF);
    put_instr(OP_JMP_ABS, 8'h00, 8'h02);
    put_instr(8'h00, 8'h00, 8'h00);

    drain();
    write_reg(CFG_INDEX_X, 8'hFF);
    write_reg(CFG_INDEX_Y, 8'hFF);
    write_reg(8'hFF, 8'h00);  // no such register, must not touch X or Y
    put_instr(OP_LDA_ZPX, 8'h80, 8'h00);
    put_instr(OP_LDA_ABSX, 8'hF0, 8'hFF);
    put_instr(OP_LDA_ABSY, 8'h01, 8'hFF);
    put_instr(OP_LDA_INDX, 8'h00, 8'h00);
    put_instr(OP_LDA_INDY, 8'hFF, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(CFG_INDEX_X, 8'h00);
          write_reg(CFG_INDEX_Y, 8'hFF);
        end
        2: begin
          write_reg(CFG_INDEX_X, 8'hFF);
          write_reg(CFG_INDEX_Y, 8'h00);
        end
        default: begin
          write_reg(CFG_INDEX_X, 8'($urandom));
          write_reg(CFG_INDEX_Y, 8'($urandom));
        end
      endcase
      write_reg(CFG_INDEX_Y + 8'($urandom_range(1, 254)), 8'($urandom));
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 9) == 0) poke(addr_t'($urandom), 8'($urandom));
        else rand_instr();
      end
    end

    drain();
    if (mirror.mismatches == 0 && mirror.results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
